### design/pkl_pkg.sv
`timescale 1ns / 1ps
package pkl_pkg;

	localparam int CAPACITY = 128;
	localparam int KEY_W = 32;
	localparam int PAY_W = 32;
	localparam int POS_W = 8;
	localparam int OP_W = 2;
	localparam int ST_W = 2;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	// wide enough to compare a position against count + 1
	localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
	localparam int ENT_W = KEY_W + PAY_W;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [ST_W-1:0] status_t;

	localparam op_t OP_INS = 2'd0;
	localparam op_t OP_SRCH = 2'd1;
	localparam op_t OP_REM = 2'd2;

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_FULL = 2'd1;
	localparam status_t ST_RANGE = 2'd2;
	localparam status_t ST_NOTFOUND = 2'd3;

endpackage

### design/pkl_req_if.sv
`timescale 1ns / 1ps
interface pkl_req_if import pkl_pkg::*;;
	logic valid;
	logic ready;
	op_t operation;
	logic signed [KEY_W-1:0] entry_key;
	logic [PAY_W-1:0] entry_payload;
	logic [POS_W-1:0] position;

	modport source (output valid, operation, entry_key, entry_payload, position, input ready);
	modport sink (input valid, operation, entry_key, entry_payload, position, output ready);
endinterface

### design/pkl_rsp_if.sv
`timescale 1ns / 1ps
interface pkl_rsp_if import pkl_pkg::*;;
	logic valid;
	logic ready;
	status_t status;
	logic [POS_W-1:0] found_position;
	logic [POS_W-1:0] entry_count;
	logic is_empty;
	logic is_full;

	modport source (output valid, status, found_position, entry_count, is_empty, is_full,
		input ready);
	modport sink (input valid, status, found_position, entry_count, is_empty, is_full,
		output ready);
endinterface

### design/positional_keyed_list.sv
`timescale 1ns / 1ps
// channel | dir | handshake   | payload
// req     | in  | valid/ready | operation, entry_key, entry_payload, position
// rsp     | out | valid/ready | status, found_position, entry_count, is_empty, is_full
//
// One item at a time: req is taken only in IDLE. Insert moves entries up, then writes
// (append only writes); remove moves entries down (last entry just dropped); search
// scans from position 1. Each moved or searched entry costs one memory read.
// arst_n clears count, sequencer and result valid; the entry memory is not cleared.
// A waiting result does not block the next item; a finished item waits in DONE
// until the result register is free.
module positional_keyed_list import pkl_pkg::*; (
	input logic clk,
	input logic arst_n,
	pkl_req_if.sink req,
	pkl_rsp_if.source rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SHUP = 3'd1; // insert: move entries up, top first
	localparam logic [2:0] S_SHDN = 3'd2; // remove: move entries down, bottom first
	localparam logic [2:0] S_INS = 3'd3; // insert: write the new entry
	localparam logic [2:0] S_SRCH = 3'd4; // search: scan from position 1
	localparam logic [2:0] S_DONE = 3'd5; // result ready for the output register

	logic [2:0] state_q;
	logic [CNT_W-1:0] count_q;

	// latched item
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic [IDX_W-1:0] pos_idx_q;

	// result under construction
	status_t st_q;
	logic [POS_W-1:0] found_q;

	// scan sequencer: read issued at rd_idx_q, data back in the next cycle (pend_*)
	logic [IDX_W-1:0] rd_idx_q;
	logic issued_q;
	logic pend_q;
	logic pend_last_q;
	logic [IDX_W-1:0] pend_a_q;

	// entry memory, {key, payload}
	logic [ENT_W-1:0] mem [CAPACITY];
	logic [ENT_W-1:0] rd_q;
	logic mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [ENT_W-1:0] mem_wd;

	logic [IDX_W-1:0] cnt_m1;
	logic [IDX_W-1:0] rd_idx_nx;
	logic last_rd;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic key_hit;
	logic out_free;

	assign req.ready = (state_q == S_IDLE);
	assign out_free = !rsp.valid || rsp.ready;

	assign cnt_m1 = IDX_W'(count_q - CNT_W'(1));
	assign pos_x = CMP_W'(req.position);
	assign cnt_x = CMP_W'(count_q);
	assign key_hit = (rd_q[ENT_W-1 -: KEY_W] == key_q);

	// shared address stepper: insert walks down, remove and search walk up
	assign rd_idx_nx = (state_q == S_SHUP) ? rd_idx_q - IDX_W'(1) : rd_idx_q + IDX_W'(1);

	always_comb begin
		unique case (state_q)
			S_SHUP: last_rd = (rd_idx_q == pos_idx_q);
			default: last_rd = (rd_idx_q == cnt_m1);
		endcase
	end

	// memory write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = pend_a_q;
		mem_wd = rd_q;
		unique case (state_q)
			S_SHUP: begin
				mem_we = pend_q;
				mem_wa = pend_a_q + IDX_W'(1);
			end
			S_SHDN: begin
				mem_we = pend_q;
				mem_wa = pend_a_q - IDX_W'(1);
			end
			S_INS: begin
				mem_we = 1'b1;
				mem_wa = pos_idx_q;
				mem_wd = {key_q, pay_q};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_idx_q];
	end

	// datapath registers of the latched item
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			key_q <= req.entry_key;
			pay_q <= req.entry_payload;
			pos_idx_q <= IDX_W'(req.position - POS_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			st_q <= ST_OK;
			found_q <= '0;
			rd_idx_q <= '0;
			issued_q <= 1'b0;
			pend_q <= 1'b0;
			pend_last_q <= 1'b0;
			pend_a_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						st_q <= ST_OK;
						found_q <= '0;
						issued_q <= 1'b0;
						pend_q <= 1'b0;
						pend_last_q <= 1'b0;
						state_q <= S_DONE;
						unique case (req.operation)
							OP_INS: begin
								if (count_q >= CNT_W'(CAPACITY)) begin
									st_q <= ST_FULL;
								end else if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
									st_q <= ST_RANGE;
								end else if (pos_x == cnt_x + CMP_W'(1)) begin
									// append: nothing to move
									state_q <= S_INS;
								end else begin
									rd_idx_q <= cnt_m1;
									state_q <= S_SHUP;
								end
							end
							OP_SRCH: begin
								if (count_q == '0) begin
									st_q <= ST_NOTFOUND;
								end else begin
									rd_idx_q <= '0;
									state_q <= S_SRCH;
								end
							end
							OP_REM: begin
								if (pos_x == '0 || pos_x > cnt_x) begin
									st_q <= ST_RANGE;
								end else if (pos_x == cnt_x) begin
									// last entry: just drop it
									count_q <= count_q - CNT_W'(1);
								end else begin
									// first entry to move sits at index position
									rd_idx_q <= IDX_W'(req.position);
									state_q <= S_SHDN;
								end
							end
							default: begin
								st_q <= ST_OK;
							end
						endcase
					end
				end
				S_SHUP, S_SHDN, S_SRCH: begin
					if (!issued_q) begin
						pend_q <= 1'b1;
						pend_a_q <= rd_idx_q;
						pend_last_q <= last_rd;
						rd_idx_q <= rd_idx_nx;
						issued_q <= last_rd;
					end else begin
						pend_q <= 1'b0;
					end
					if (state_q == S_SHUP) begin
						if (pend_q && pend_last_q) begin
							state_q <= S_INS;
						end
					end else if (state_q == S_SHDN) begin
						if (pend_q && pend_last_q) begin
							count_q <= count_q - CNT_W'(1);
							state_q <= S_DONE;
						end
					end else begin
						if (pend_q && key_hit) begin
							st_q <= ST_OK;
							found_q <= POS_W'(pend_a_q) + POS_W'(1);
							state_q <= S_DONE;
						end else if (pend_q && pend_last_q) begin
							st_q <= ST_NOTFOUND;
							state_q <= S_DONE;
						end
					end
				end
				S_INS: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp.status <= st_q;
			rsp.found_position <= found_q;
			rsp.entry_count <= POS_W'(count_q);
			rsp.is_empty <= (count_q == '0);
			rsp.is_full <= (count_q == CNT_W'(CAPACITY));
		end
	end

`ifndef SYNTHESIS
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == $past(count_q) + CNT_W'(1) || count_q == $past(count_q) - CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q) == S_DONE)
		else $error("result raised outside DONE");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("memory written while not working an item");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.found_position == '0 || rsp.status == ST_OK))
		else $error("found position with failing status");
`endif

endmodule
